/* sv/masd_pkg.sv */
// Shared constants for the moving-average spike detector.
// Holds parameter defaults, register reset values and register indexes.
// No dependencies.
package masd_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Configuration port layout.
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int WIN_REG_BITS = 7;
    localparam int THR_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_Q8 = 1'b1;

    localparam int WIN_RESET = 20;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd512;

    // Fractional bits of the Q8.8 score and quotient bits produced by the divider.
    localparam int FRAC_BITS = 8;
    localparam int QUOT_BITS = 16;

endpackage

/* sv/moving_average_spike_detector.sv */
// Moving-average spike detector: sample ring in a synchronous memory, running sum,
// and a radix-2 divider producing a Q8.8 ratio plus buy and sell flags.
// Depends on masd_pkg.
//
// Usage:
//   Slave stream (i_s_*): one sample per transaction; tdata carries the sample,
//   tuser carries the restart flag, which clears the history before the sample.
//   Master stream (o_m_*): one result per sample; tdata carries the score, tuser
//   carries score_valid, buy and sell.
//   Configuration: i_cfg_we writes window_len (index 0) or threshold_q8 (index 1).
//   Writing window_len also clears the history.
// Operation:
//   An accepted sample reads its ring slot, then updates the sum and ring and
//   forms sample*window, prepares the divider and then runs 16 divider steps,
//   one quotient bit a cycle, with the sell product accumulated alongside.
//   The result is registered from the done state, and a new sample is taken
//   only once the block is back in idle, so no new sample enters while the
//   last one is still in the shift-subtract divider.
//   The result register lets the next sample be accepted while a result still
//   waits; if the receiver stalls, the block holds the finished item until the
//   output register frees and accepts nothing more meanwhile.
// Reset: synchronous, active low; window 20, threshold 2.0, empty history.
module moving_average_spike_detector #(
    parameter int WINDOW_MAX  = masd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = masd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // tdata: sample [SAMPLE_BITS-1:0], zero padding above
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          i_s_tdata,
    // tuser: restart [0]
    input  logic                                      i_s_tuser,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // tdata: score [15:0]
    output logic [15:0]                               o_m_tdata,
    // tuser: score_valid [0], buy [1], sell [2]
    output logic [2:0]                                o_m_tuser,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    input  logic                                      i_cfg_we,
    input  logic [masd_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  logic [masd_pkg::CFG_DATA_BITS-1:0]        i_cfg_wdata
);

    localparam int WB = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int VW = SAMPLE_BITS + WB;
    localparam int RW = VW + masd_pkg::QUOT_BITS;
    localparam int FB = masd_pkg::FRAC_BITS;
    localparam int QB = masd_pkg::QUOT_BITS;
    localparam int TB = masd_pkg::THR_BITS;
    localparam int CNTW = $clog2(QB);
    localparam int RESET_WIN = (masd_pkg::WIN_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                  : masd_pkg::WIN_RESET;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [WB-1:0]          r_win;
    logic [TB-1:0]          r_thr;
    logic [VW-1:0]          r_sum;
    logic [WB-1:0]          r_seen;
    logic [AW-1:0]          r_slot;
    logic [AW-1:0]          r_cur_slot;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_restart;
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic [VW-1:0]          r_scaled;
    logic                   r_valid;
    logic                   r_sat;
    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          r_dsh;
    logic [RW-1:0]          r_acc;
    logic [TB-1:0]          r_tsh;
    logic [QB-1:0]          r_q;
    logic [CNTW-1:0]        r_cnt;
    logic                   r_out_valid;
    logic [15:0]            r_out_score;
    logic [2:0]             r_out_user;

    logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

    logic                   accept;
    logic                   load;
    logic [AW-1:0]          base_slot;
    logic [AW-1:0]          acc_slot;
    logic [WB-1:0]          seen_eff;
    logic [VW-1:0]          sum_eff;
    logic                   full_before;
    logic [VW-1:0]          n_sum;
    logic [WB-1:0]          n_seen;
    logic [WB:0]            slot_inc;
    logic [AW-1:0]          n_slot;
    logic                   div_ge;
    logic                   sell_lt;
    logic [WB-1:0]          cfg_win;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign load       = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_score;
    assign o_m_tuser  = r_out_user;

    // Window register value after clamping into 1..WINDOW_MAX.
    always_comb begin
        if (i_cfg_wdata[masd_pkg::WIN_REG_BITS-1:0] == '0) begin
            cfg_win = WB'(1);
        end else if (32'(i_cfg_wdata[masd_pkg::WIN_REG_BITS-1:0]) > WINDOW_MAX) begin
            cfg_win = WB'(WINDOW_MAX);
        end else begin
            cfg_win = WB'(i_cfg_wdata[masd_pkg::WIN_REG_BITS-1:0]);
        end
    end

    // Slot for the incoming sample; a restart starts again at slot zero.
    always_comb begin
        base_slot = i_s_tuser ? '0 : r_slot;
        if ((WB+1)'(base_slot) >= (WB+1)'(r_win)) begin
            acc_slot = '0;
        end else begin
            acc_slot = base_slot;
        end
    end

    // Series update once the old ring entry is back from memory.
    always_comb begin
        seen_eff    = r_restart ? '0 : r_seen;
        sum_eff     = r_restart ? '0 : r_sum;
        full_before = (seen_eff >= r_win);
        n_sum       = sum_eff - (full_before ? VW'(r_rdata) : '0) + VW'(r_sample);
        n_seen      = full_before ? seen_eff : seen_eff + WB'(1);
        slot_inc    = (WB+1)'(r_cur_slot) + (WB+1)'(1);
        n_slot      = (slot_inc >= (WB+1)'(r_win)) ? '0 : AW'(slot_inc);
    end

    assign div_ge  = (r_rem >= r_dsh);
    assign sell_lt = (r_acc < (RW'(r_sum) << FB));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_READ;
            end
            S_READ: n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNTW'(QB - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Ring memory: one read or one write a cycle, registered read data.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            mem[r_cur_slot] <= r_sample;
        end
        if (accept) begin
            r_rdata <= mem[acc_slot];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WB'(RESET_WIN);
            r_thr       <= masd_pkg::THR_RESET;
            r_sum       <= '0;
            r_seen      <= '0;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    masd_pkg::REG_WINDOW_LEN: begin
                        r_win  <= cfg_win;
                        r_sum  <= '0;
                        r_seen <= '0;
                        r_slot <= '0;
                    end
                    masd_pkg::REG_THRESHOLD_Q8: r_thr <= i_cfg_wdata[TB-1:0];
                    default: ;
                endcase
            end else if (r_state == S_READ) begin
                r_sum  <= n_sum;
                r_seen <= n_seen;
                r_slot <= n_slot;
            end
            if (r_state == S_PREP) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample   <= i_s_tdata[SAMPLE_BITS-1:0];
            r_restart  <= i_s_tuser;
            r_cur_slot <= acc_slot;
        end
        if (r_state == S_READ) begin
            r_scaled <= VW'(r_sample) * VW'(r_win);
            r_valid  <= (n_seen >= r_win) && (n_sum != '0);
        end
        if (r_state == S_PREP) begin
            // At or above 256 the score saturates and the divider result is unused.
            r_sat <= (RW'(r_scaled) >= (RW'(r_sum) << FB));
            r_rem <= RW'(r_scaled) << FB;
            r_dsh <= RW'(r_sum) << (QB - 1);
            r_acc <= '0;
            r_tsh <= r_thr;
            r_q   <= '0;
        end
        if (r_state == S_DIV) begin
            if (div_ge) r_rem <= r_rem - r_dsh;
            r_q   <= {r_q[QB-2:0], div_ge};
            r_dsh <= r_dsh >> 1;
            // Serial sample*window*threshold for the sell comparison, MSB first.
            r_acc <= (r_acc << 1) + (r_tsh[TB-1] ? RW'(r_scaled) : '0);
            r_tsh <= r_tsh << 1;
        end
        if (load) begin
            if (r_valid) begin
                r_out_score <= r_sat ? 16'hFFFF : r_q;
                // The Q8.8 quotient is exact against an integer threshold.
                r_out_user  <= {sell_lt, (r_sat || (r_q >= r_thr)), 1'b1};
            end else begin
                r_out_score <= '0;
                r_out_user  <= 3'b000;
            end
        end
    end

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= r_win)
        else $error("history count exceeds the window");

    a_slot_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WB+1)'(r_slot) < (WB+1)'(r_win))
        else $error("write slot outside the window");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_cfg_we) |=> (r_state == S_READ))
        else $error("accepted transaction did not start a ring read");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_tready) |=>
            (r_state == S_DONE && r_out_valid))
        else $error("finished item left while the output was still occupied");

endmodule
